// ----- design/bwlp_pkg.sv -----
`default_nettype none

package bwlp_pkg;

    localparam int CHANNELS  = 256;
    localparam int SAMPLE_W  = 32;
    localparam int COEF_W    = 32;
    localparam int COEF_FRAC = 30;
    localparam int CHAN_W    = 8;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;

    // x0 + 2*x1 + x2 needs two more bits than a sample
    localparam int SUM_W   = SAMPLE_W + 2;
    localparam int PROD0_W = COEF_W + SUM_W;
    localparam int PROD_W  = COEF_W + SAMPLE_W;
    localparam int Y_W     = PROD0_W - COEF_FRAC + 2;

    localparam logic [OP_W-1:0] OP_FILTER = OP_W'(0);
    localparam logic [OP_W-1:0] OP_SEED   = OP_W'(1);
    localparam logic [OP_W-1:0] OP_READ   = OP_W'(2);

    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FB_ONE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_FB_TWO = CFG_IDX_W'(2);

    localparam logic [COEF_W-1:0] GAIN_RESET   = COEF_W'(47393246);
    localparam logic [COEF_W-1:0] FB_ONE_RESET = COEF_W'(-1421797384);
    localparam logic [COEF_W-1:0] FB_TWO_RESET = COEF_W'(537628974);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x1;
        logic signed [SAMPLE_W-1:0] x2;
        logic signed [SAMPLE_W-1:0] y1;
        logic signed [SAMPLE_W-1:0] y2;
    } hist_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] gain;
        logic signed [COEF_W-1:0] fb_one;
        logic signed [COEF_W-1:0] fb_two;
    } coef_t;

endpackage

`default_nettype wire

// ----- design/bwlp_if.sv -----
`default_nettype none

interface bwlp_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [bwlp_pkg::OP_W-1:0]            operation;
    logic [bwlp_pkg::CHAN_W-1:0]          channel;
    logic signed [bwlp_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, operation, channel, sample, input ready);
    modport sink (input valid, operation, channel, sample, output ready);
endinterface

interface bwlp_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [bwlp_pkg::SAMPLE_W-1:0] value;
    logic                                 saturated;

    modport source (output valid, value, saturated, input ready);
    modport sink (input valid, value, saturated, output ready);
endinterface

`default_nettype wire

// ----- design/bwlp_arith.sv -----
`default_nettype none

module bwlp_arith (
    input  wire logic                                 clk,
    input  wire logic                                 en,
    input  wire bwlp_pkg::coef_t                      coef,
    input  wire logic signed [bwlp_pkg::SAMPLE_W-1:0] x0,
    input  wire bwlp_pkg::hist_t                      hist,
    output logic signed [bwlp_pkg::SAMPLE_W-1:0]      y,
    output logic                                      sat
);

    localparam int R0_W = bwlp_pkg::PROD0_W - bwlp_pkg::COEF_FRAC;
    localparam int R_W  = bwlp_pkg::PROD_W - bwlp_pkg::COEF_FRAC;

    localparam logic signed [bwlp_pkg::PROD0_W-1:0] HALF0 =
        bwlp_pkg::PROD0_W'(1) << (bwlp_pkg::COEF_FRAC - 1);
    localparam logic signed [bwlp_pkg::PROD_W-1:0] HALF =
        bwlp_pkg::PROD_W'(1) << (bwlp_pkg::COEF_FRAC - 1);
    localparam logic signed [bwlp_pkg::Y_W-1:0] Y_MAX =
        bwlp_pkg::Y_W'({1'b0, {(bwlp_pkg::SAMPLE_W-1){1'b1}}});
    localparam logic signed [bwlp_pkg::Y_W-1:0] Y_MIN = -Y_MAX - bwlp_pkg::Y_W'(1);

    logic signed [bwlp_pkg::SUM_W-1:0]   sum;
    logic signed [bwlp_pkg::PROD0_W-1:0] p0_next;
    logic signed [bwlp_pkg::PROD0_W-1:0] p0_reg;
    logic signed [bwlp_pkg::PROD_W-1:0]  p1_next;
    logic signed [bwlp_pkg::PROD_W-1:0]  p1_reg;
    logic signed [bwlp_pkg::PROD_W-1:0]  p2_next;
    logic signed [bwlp_pkg::PROD_W-1:0]  p2_reg;
    logic signed [bwlp_pkg::PROD0_W-1:0] p0_half;
    logic signed [bwlp_pkg::PROD_W-1:0]  p1_half;
    logic signed [bwlp_pkg::PROD_W-1:0]  p2_half;
    logic signed [R0_W-1:0]              r0;
    logic signed [R_W-1:0]               r1;
    logic signed [R_W-1:0]               r2;
    logic signed [bwlp_pkg::Y_W-1:0]     y_full;
    logic                                over;
    logic                                under;

    assign sum = bwlp_pkg::SUM_W'(x0) + (bwlp_pkg::SUM_W'(hist.x1) <<< 1)
               + bwlp_pkg::SUM_W'(hist.x2);

    assign p0_next = coef.gain * sum;
    assign p1_next = coef.fb_one * hist.y1;
    assign p2_next = coef.fb_two * hist.y2;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
    end

    // round to nearest, ties toward plus infinity
    assign p0_half = p0_reg + HALF0;
    assign p1_half = p1_reg + HALF;
    assign p2_half = p2_reg + HALF;
    assign r0 = R0_W'(p0_half >>> bwlp_pkg::COEF_FRAC);
    assign r1 = R_W'(p1_half >>> bwlp_pkg::COEF_FRAC);
    assign r2 = R_W'(p2_half >>> bwlp_pkg::COEF_FRAC);

    assign y_full = bwlp_pkg::Y_W'(r0) - bwlp_pkg::Y_W'(r1) - bwlp_pkg::Y_W'(r2);
    assign over   = y_full > Y_MAX;
    assign under  = y_full < Y_MIN;
    assign sat    = over || under;

    always_comb
    begin
        priority if (over)
            y = bwlp_pkg::SAMPLE_W'(Y_MAX);
        else if (under)
            y = bwlp_pkg::SAMPLE_W'(Y_MIN);
        else
            y = y_full[bwlp_pkg::SAMPLE_W-1:0];
    end

endmodule

`default_nettype wire

// ----- design/multichannel_butterworth_lowpass_top.sv -----
// Second-order Butterworth low-pass filter over 256 channels, one request per clock unless
// stalled. A request reads its channel's history (two past inputs, two past outputs) from a
// synchronous memory at acceptance, multiplies in the next stage, rounds, saturates and writes
// the history back in the stage after that, then lands in the output register; the stages stall
// while the output side is not ready. Requests to different channels stream at one per cycle
// while the output side is ready; a request right behind a filter or seed on the same channel
// waits for that write-back, then picks it up by forwarding. History starts at zero through
// per-channel valid bits, so there is no clearing pass after reset. Coefficients are Q2.30; the
// user must write them through the cfg port while no request is in flight; the block does not enforce this.
`default_nettype none

module multichannel_butterworth_lowpass_top (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    bwlp_req_if.sink                                   req,
    bwlp_rsp_if.source                                 rsp,
    input  wire logic                                  cfg_we,
    input  wire logic [bwlp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [bwlp_pkg::COEF_W-1:0]           cfg_data
);

    bwlp_pkg::coef_t coef_reg;

    bwlp_pkg::hist_t mem [bwlp_pkg::CHANNELS];
    logic [bwlp_pkg::CHANNELS-1:0] vbits_reg;

    // stage a: history read
    logic                                 a_valid_reg;
    logic                                 a_first_reg;
    logic                                 a_vld_reg;
    logic [bwlp_pkg::OP_W-1:0]            a_op_reg;
    logic [bwlp_pkg::CHAN_W-1:0]          a_ch_reg;
    logic signed [bwlp_pkg::SAMPLE_W-1:0] a_x_reg;
    bwlp_pkg::hist_t                      rd_data_reg;
    bwlp_pkg::hist_t                      hold_reg;
    bwlp_pkg::hist_t                      hold_next;
    bwlp_pkg::hist_t                      a_hist;
    logic                                 a_chok;
    logic                                 a_advance;
    logic                                 hazard;

    // stage b: combine and write back
    logic                                 b_valid_reg;
    logic                                 b_chok_reg;
    logic [bwlp_pkg::OP_W-1:0]            b_op_reg;
    logic [bwlp_pkg::CHAN_W-1:0]          b_ch_reg;
    logic signed [bwlp_pkg::SAMPLE_W-1:0] b_x_reg;
    logic signed [bwlp_pkg::SAMPLE_W-1:0] b_x1_reg;
    logic signed [bwlp_pkg::SAMPLE_W-1:0] b_y1_reg;
    logic                                 b_writes;
    logic                                 b_advance;
    logic                                 b_free;
    logic                                 commit_write;
    bwlp_pkg::hist_t                      new_entry;
    logic signed [bwlp_pkg::SAMPLE_W-1:0] b_value;
    logic                                 b_sat;
    logic signed [bwlp_pkg::SAMPLE_W-1:0] y;
    logic                                 y_sat;

    // last write, for a read issued at the same edge
    logic                                 wb_valid_reg;
    logic [bwlp_pkg::CHAN_W-1:0]          wb_ch_reg;
    bwlp_pkg::hist_t                      wb_data_reg;

    logic                                 o_valid_reg;
    logic signed [bwlp_pkg::SAMPLE_W-1:0] o_value_reg;
    logic                                 o_sat_reg;
    logic                                 o_free;
    logic                                 accept;

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.gain   <= bwlp_pkg::GAIN_RESET;
            coef_reg.fb_one <= bwlp_pkg::FB_ONE_RESET;
            coef_reg.fb_two <= bwlp_pkg::FB_TWO_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bwlp_pkg::REG_GAIN:   coef_reg.gain   <= cfg_data;
                bwlp_pkg::REG_FB_ONE: coef_reg.fb_one <= cfg_data;
                bwlp_pkg::REG_FB_TWO: coef_reg.fb_two <= cfg_data;
                default:              ;
            endcase
        end
    end

    assign o_free    = !o_valid_reg || rsp.ready;
    assign b_advance = b_valid_reg && o_free;
    assign b_free    = !b_valid_reg || b_advance;
    assign b_writes  = b_valid_reg && b_chok_reg
                    && (b_op_reg == bwlp_pkg::OP_FILTER || b_op_reg == bwlp_pkg::OP_SEED);
    assign commit_write = b_advance && b_writes;

    assign a_chok    = 32'(a_ch_reg) < bwlp_pkg::CHANNELS;
    assign hazard    = b_writes && (b_ch_reg == a_ch_reg);
    assign a_advance = a_valid_reg && b_free && !hazard;

    assign req.ready = !a_valid_reg || a_advance;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        if (!a_first_reg)
            a_hist = hold_reg;
        else if (wb_valid_reg && wb_ch_reg == a_ch_reg)
            a_hist = wb_data_reg;
        else if (a_vld_reg)
            a_hist = rd_data_reg;
        else
            a_hist = '0;
    end

    // while stalled, keep the resolved history and fold in a write that lands now
    assign hold_next = (commit_write && b_ch_reg == a_ch_reg) ? new_entry : a_hist;

    bwlp_arith u_arith (
        .clk  (clk),
        .en   (a_advance),
        .coef (coef_reg),
        .x0   (a_x_reg),
        .hist (a_hist),
        .y    (y),
        .sat  (y_sat)
    );

    always_comb
    begin
        new_entry = '0;
        b_value   = '0;
        b_sat     = 1'b0;
        if (b_chok_reg)
        begin
            unique case (b_op_reg)
                bwlp_pkg::OP_FILTER:
                begin
                    new_entry.x1 = b_x_reg;
                    new_entry.x2 = b_x1_reg;
                    new_entry.y1 = y;
                    new_entry.y2 = b_y1_reg;
                    b_value      = y;
                    b_sat        = y_sat;
                end
                bwlp_pkg::OP_SEED:
                begin
                    new_entry.x1 = b_x_reg;
                    new_entry.x2 = b_x_reg;
                    new_entry.y1 = b_x_reg;
                    new_entry.y2 = b_x_reg;
                    b_value      = b_x_reg;
                end
                bwlp_pkg::OP_READ:
                begin
                    b_value = b_y1_reg;
                end
                default:
                begin
                    b_value = '0;
                end
            endcase
        end
    end

    // history memory
    always_ff @(posedge clk)
    begin
        if (commit_write)
            mem[b_ch_reg] <= new_entry;
        if (accept)
            rd_data_reg <= mem[req.channel];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            a_first_reg  <= 1'b0;
            a_vld_reg    <= 1'b0;
            b_valid_reg  <= 1'b0;
            o_valid_reg  <= 1'b0;
            wb_valid_reg <= 1'b0;
            vbits_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                a_valid_reg <= 1'b1;
                a_first_reg <= 1'b1;
                a_vld_reg   <= vbits_reg[req.channel];
            end
            else if (a_advance)
                a_valid_reg <= 1'b0;
            else
                a_first_reg <= 1'b0;

            if (a_advance)
                b_valid_reg <= 1'b1;
            else if (b_advance)
                b_valid_reg <= 1'b0;

            if (b_advance)
                o_valid_reg <= 1'b1;
            else if (rsp.ready)
                o_valid_reg <= 1'b0;

            wb_valid_reg <= commit_write;
            if (commit_write)
                vbits_reg[b_ch_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        if (accept)
        begin
            a_op_reg <= req.operation;
            a_ch_reg <= req.channel;
            a_x_reg  <= req.sample;
        end
        if (a_advance)
        begin
            b_op_reg   <= a_op_reg;
            b_ch_reg   <= a_ch_reg;
            b_chok_reg <= a_chok;
            b_x_reg    <= a_x_reg;
            b_x1_reg   <= a_hist.x1;
            b_y1_reg   <= a_hist.y1;
        end
        if (b_advance)
        begin
            o_value_reg <= b_value;
            o_sat_reg   <= b_sat;
        end
        if (commit_write)
        begin
            wb_ch_reg   <= b_ch_reg;
            wb_data_reg <= new_entry;
        end
    end

    assign rsp.valid     = o_valid_reg;
    assign rsp.value     = o_value_reg;
    assign rsp.saturated = o_sat_reg;

    a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        commit_write |=> vbits_reg[$past(b_ch_reg)])
        else $error("history write did not mark its channel valid");

    a_result_from_stage_b: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(o_valid_reg) |-> $past(b_advance))
        else $error("result appeared without a stage b item");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.saturated |->
            (rsp.value[bwlp_pkg::SAMPLE_W-1] && rsp.value[bwlp_pkg::SAMPLE_W-2:0] == '0)
            || (!rsp.value[bwlp_pkg::SAMPLE_W-1] && (&rsp.value[bwlp_pkg::SAMPLE_W-2:0])))
        else $error("saturated result not at a range limit");

    a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !a_advance |=> a_valid_reg && $stable(a_ch_reg))
        else $error("stalled stage a item lost or changed");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bwlp_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = OP_W'(3);

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0]   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0]   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0]   COEF_ONE   = COEF_W'(1) << COEF_FRAC;
    localparam logic signed [COEF_W-1:0]   COEF_HALF  = COEF_W'(1) << (COEF_FRAC - 1);

    localparam logic signed [95:0] ROUND_HALF = 96'sd1 <<< (COEF_FRAC - 1);
    localparam logic signed [95:0] WIDE_MAX   = 96'(SAMPLE_MAX);
    localparam logic signed [95:0] WIDE_MIN   = 96'(SAMPLE_MIN);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       saturated;
    } filter_out_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COEF_W-1:0]    cfg_data;

    bwlp_req_if req ();
    bwlp_rsp_if rsp ();

    multichannel_butterworth_lowpass_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // per-channel filter history as the block should hold it
    logic signed [SAMPLE_W-1:0] x_one [CHANNELS];
    logic signed [SAMPLE_W-1:0] x_two [CHANNELS];
    logic signed [SAMPLE_W-1:0] y_one [CHANNELS];
    logic signed [SAMPLE_W-1:0] y_two [CHANNELS];
    logic signed [COEF_W-1:0]   gain_q30;
    logic signed [COEF_W-1:0]   fb_one_q30;
    logic signed [COEF_W-1:0]   fb_two_q30;

    filter_out_t pending_outputs [$];
    int          mismatch_count = 0;
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // coef * operand / 2^30, ties toward plus infinity
    function automatic logic signed [95:0] q30_product(logic signed [COEF_W-1:0] coef,
                                                       logic signed [95:0] operand);
        logic signed [95:0] wide_coef;
        wide_coef = coef;
        return (wide_coef * operand + ROUND_HALF) >>> COEF_FRAC;
    endfunction

    function automatic filter_out_t filter_step(logic [OP_W-1:0] op, logic [CHAN_W-1:0] ch,
                                                logic signed [SAMPLE_W-1:0] smp);
        filter_out_t        res;
        logic signed [95:0] tap_sum;
        logic signed [95:0] acc;
        res.value     = '0;
        res.saturated = 1'b0;
        if (int'(ch) < CHANNELS)
        begin
            case (op)
                OP_FILTER:
                begin
                    tap_sum = smp;
                    tap_sum = tap_sum + 2 * x_one[ch] + x_two[ch];
                    acc = q30_product(gain_q30, tap_sum)
                        - q30_product(fb_one_q30, y_one[ch])
                        - q30_product(fb_two_q30, y_two[ch]);
                    if (acc > WIDE_MAX)
                    begin
                        acc           = WIDE_MAX;
                        res.saturated = 1'b1;
                    end
                    else if (acc < WIDE_MIN)
                    begin
                        acc           = WIDE_MIN;
                        res.saturated = 1'b1;
                    end
                    x_two[ch] = x_one[ch];
                    x_one[ch] = smp;
                    y_two[ch] = y_one[ch];
                    y_one[ch] = acc[SAMPLE_W-1:0];
                    res.value = acc[SAMPLE_W-1:0];
                end
                OP_SEED:
                begin
                    x_one[ch] = smp;
                    x_two[ch] = smp;
                    y_one[ch] = smp;
                    y_two[ch] = smp;
                    res.value = smp;
                end
                OP_READ:
                    res.value = y_one[ch];
                default:
                    res.value = '0;
            endcase
        end
        return res;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return SAMPLE_W'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
            4, 5, 6, 7: return $urandom();
            8:          return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            default:    return SAMPLE_W'($signed($urandom_range(0, 2)) - 1);
        endcase
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op, input logic [CHAN_W-1:0] ch,
                                input logic signed [SAMPLE_W-1:0] smp);
        int gap;
        if ($urandom_range(0, 31) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 16);
        @(negedge clk);
        if (gap > 0)
        begin
            req.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid     = 1'b1;
        req.operation = op;
        req.channel   = ch;
        req.sample    = smp;
        do
            @(posedge clk);
        while (!req.ready);
        pending_outputs.insert(pending_outputs.size(), filter_step(op, ch, smp));
    endtask

    // drop valid and let the pipeline drain
    task automatic wait_for_idle();
        @(negedge clk);
        req.valid = 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx,
                              input logic signed [COEF_W-1:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        case (idx)
            REG_GAIN:   gain_q30   = val;
            REG_FB_ONE: fb_one_q30 = val;
            REG_FB_TWO: fb_two_q30 = val;
            default:    ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_coefs(input logic signed [COEF_W-1:0] gain,
                             input logic signed [COEF_W-1:0] fb_one,
                             input logic signed [COEF_W-1:0] fb_two);
        wait_for_idle();
        write_coef(REG_GAIN, gain);
        write_coef(REG_FB_ONE, fb_one);
        write_coef(REG_FB_TWO, fb_two);
    endtask

    task automatic run_random_items(input int count);
        logic [CHAN_W-1:0]          hot [4];
        logic [OP_W-1:0]            op;
        logic [CHAN_W-1:0]          ch;
        logic signed [SAMPLE_W-1:0] smp;
        int                         pick;
        foreach (hot[k])
            hot[k] = $urandom_range(0, CHANNELS - 1);
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                op = OP_FILTER;
            else if (pick < 82)
                op = OP_SEED;
            else if (pick < 94)
                op = OP_READ;
            else
                op = OP_UNUSED;
            // a few hot channels keep same-channel requests back to back
            if ($urandom_range(0, 9) < 6)
                ch = hot[$urandom_range(0, 3)];
            else
                ch = $urandom_range(0, CHANNELS - 1);
            smp = draw_sample();
            send_request(op, ch, smp);
        end
    endtask

    task automatic test_reset_state();
        send_request(OP_READ, 0, 0);
        send_request(OP_READ, CHANNELS - 1, 32'sh1234_5678);
        send_request(OP_FILTER, 0, SAMPLE_MAX);
        send_request(OP_FILTER, 0, SAMPLE_MIN);
        send_request(OP_FILTER, 0, 0);
        send_request(OP_FILTER, CHANNELS - 1, -1);
        send_request(OP_FILTER, CHANNELS - 1, 1);
        send_request(OP_UNUSED, 3, 32'sh0001_0000);
        send_request(OP_READ, 0, SAMPLE_MIN);
        send_request(OP_SEED, 7, SAMPLE_MAX);
        send_request(OP_FILTER, 7, SAMPLE_MAX);
        send_request(OP_READ, 7, 0);
    endtask

    task automatic test_coef_extremes();
        set_coefs(COEF_MAX, COEF_MIN, COEF_MAX);
        send_request(OP_SEED, 10, SAMPLE_MAX);
        send_request(OP_FILTER, 10, SAMPLE_MAX);
        send_request(OP_FILTER, 10, SAMPLE_MIN);
        set_coefs(COEF_MIN, COEF_MAX, COEF_MIN);
        send_request(OP_SEED, 11, SAMPLE_MIN);
        send_request(OP_FILTER, 11, SAMPLE_MIN);
        set_coefs(0, 0, 0);
        send_request(OP_FILTER, 12, SAMPLE_MAX);
        set_coefs(COEF_ONE, 0, 0);
        send_request(OP_FILTER, 13, SAMPLE_MAX);
    endtask

    // gain of one half puts odd tap sums exactly between two steps
    task automatic test_rounding_ties();
        set_coefs(COEF_HALF, 0, 0);
        send_request(OP_SEED, 20, 0);
        send_request(OP_FILTER, 20, 1);
        send_request(OP_SEED, 21, 0);
        send_request(OP_FILTER, 21, -1);
    endtask

    task automatic test_default_coefs_random();
        set_coefs(GAIN_RESET, FB_ONE_RESET, FB_TWO_RESET);
        run_random_items(300);
    endtask

    task automatic test_butterworth_random();
        real c;
        real g;
        for (int n = 0; n < 3; n++)
        begin
            c = $urandom_range(110, 2000) / 100.0;
            g = 1.0 / (1.0 + c * c + 1.414 * c);
            set_coefs($rtoi(g * 2.0 ** 30), $rtoi((2.0 - 2.0 * c * c) * g * 2.0 ** 30),
                      $rtoi((c * c - 1.414 * c + 1.0) * g * 2.0 ** 30));
            run_random_items(100);
        end
    endtask

    task automatic test_full_range_random();
        for (int n = 0; n < 3; n++)
        begin
            set_coefs($urandom(), $urandom(), $urandom());
            run_random_items(100);
        end
    endtask

    task automatic test_extreme_coefs_random();
        set_coefs(COEF_MIN, COEF_MIN, COEF_MIN);
        run_random_items(150);
        set_coefs(COEF_MAX, COEF_MAX, COEF_MAX);
        run_random_items(150);
    endtask

    // result side: random stalls, compare against the oldest request still open
    initial
    begin
        int          stall;
        filter_out_t exp;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                recv_burst = !recv_burst;
            stall = recv_burst ? 0 : $urandom_range(0, 16);
            @(negedge clk);
            if (stall > 0)
            begin
                rsp.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp.ready = 1'b1;
            do
                @(posedge clk);
            while (!rsp.valid);
            if (pending_outputs.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual value %0d saturated %0b",
                         $time, rsp.value, rsp.saturated);
                mismatch_count++;
            end
            else
            begin
                exp = pending_outputs.pop_front();
                if (rsp.value !== exp.value)
                begin
                    $display("%0t: value mismatch, expected %0d, actual %0d",
                             $time, exp.value, rsp.value);
                    mismatch_count++;
                end
                if (rsp.saturated !== exp.saturated)
                begin
                    $display("%0t: saturated mismatch, expected %0b, actual %0b",
                             $time, exp.saturated, rsp.saturated);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_GAIN;
        cfg_data      = '0;
        req.valid     = 1'b0;
        req.operation = OP_FILTER;
        req.channel   = '0;
        req.sample    = '0;
        gain_q30      = GAIN_RESET;
        fb_one_q30    = FB_ONE_RESET;
        fb_two_q30    = FB_TWO_RESET;
        for (int k = 0; k < CHANNELS; k++)
        begin
            x_one[k] = '0;
            x_two[k] = '0;
            y_one[k] = '0;
            y_two[k] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_coef_extremes();
        test_rounding_ties();
        test_default_coefs_random();
        test_butterworth_random();
        test_full_range_random();
        test_extreme_coefs_random();
        wait_for_idle();

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
design/bwlp_pkg.sv
design/bwlp_if.sv
design/bwlp_arith.sv
design/multichannel_butterworth_lowpass_top.sv
tb/tb.sv
